[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Wraps concurrent assertions so that synthesis builds see empty bodies.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

[sv/fsd_pkg.sv]
// ---------------------------------------------------------------------------
// Flux stream decoder package
// Shared types, parser states, byte codes and result layout.
// ---------------------------------------------------------------------------
package fsd_pkg;

	// Default width of the sample time accumulator.
	localparam int TIME_BITS_DEFAULT = 32;

	// Parser states.
	typedef enum logic [3:0] {
		ST_CODE       = 4'd0,
		ST_CELL_LO    = 4'd1,
		ST_SKIP       = 4'd2,
		ST_V16_HI     = 4'd3,
		ST_V16_LO     = 4'd4,
		ST_OOB_TYPE   = 4'd5,
		ST_OOB_LEN_LO = 4'd6,
		ST_OOB_LEN_HI = 4'd7,
		ST_OOB_DATA   = 4'd8,
		ST_OOB_BAD    = 4'd9
	} parse_state_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_FLUX  = 2'd0,
		KIND_INDEX = 2'd1,
		KIND_END   = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	// Error codes.
	typedef enum logic [1:0] {
		ERR_NONE          = 2'd0,
		ERR_TRUNCATED     = 2'd1,
		ERR_BAD_INDEX_LEN = 2'd2
	} error_code_t;

	// Stream byte codes.
	localparam logic [7:0] CODE_CELL2_LIMIT = 8'd8;
	localparam logic [7:0] CODE_PAD         = 8'd8;
	localparam logic [7:0] CODE_SKIP1       = 8'd9;
	localparam logic [7:0] CODE_SKIP2       = 8'd10;
	localparam logic [7:0] CODE_OVERFLOW    = 8'd11;
	localparam logic [7:0] CODE_VALUE16     = 8'd12;
	localparam logic [7:0] CODE_OOB         = 8'd13;

	// Out-of-band block types and sizes.
	localparam logic [7:0]  BLOCK_INDEX  = 8'd2;
	localparam logic [7:0]  BLOCK_END    = 8'd13;
	localparam logic [15:0] INDEX_LEN    = 16'd12;
	localparam logic [31:0] OOB_OVERHEAD = 32'd3;

	// Time added by an overflow code.
	localparam logic [16:0] OVERFLOW_DELTA = 17'h10000;

	// One result item.
	typedef struct packed {
		kind_t       kind;
		logic [31:0] sample_time;
		logic [31:0] element_pos;
		logic [31:0] index_stream_pos;
		logic [31:0] index_timer;
		logic [31:0] index_sys_time;
		error_code_t error_code;
	} result_t;

endpackage

[sv/fsd_in_stage.sv]
// ---------------------------------------------------------------------------
// Flux stream decoder input stage
// Registers one stream byte and hands it to the parser when there is room.
// ---------------------------------------------------------------------------
module fsd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_data,
	input  logic       space,
	output logic       take,
	output logic [7:0] data_s1,
	output logic       eod_s1
);
	import fsd_pkg::*;

	logic valid_s1;

	// The held byte moves on when the result register can take a result.
	assign take       = valid_s1 && space;
	assign byte_ready = !valid_s1 || take;

	// Valid flag of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	// Payload of the input register.
	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			data_s1 <= data_byte;
			eod_s1  <= end_of_data;
		end
	end

endmodule

[sv/fsd_parser.sv]
// ---------------------------------------------------------------------------
// Flux stream decoder parser
// Byte-at-a-time state machine that keeps time, positions and index words.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fsd_parser #(
	parameter int TIME_BITS = fsd_pkg::TIME_BITS_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      data_byte,
	input  logic            end_of_data,
	output logic            res_valid,
	output fsd_pkg::result_t res
);
	import fsd_pkg::*;

	parse_state_t         state_q, state_n;
	logic [TIME_BITS-1:0] time_q, time_n;
	logic [31:0]          stream_pos_q, stream_pos_n;
	logic [31:0]          elem_start_q, elem_start_n;
	logic [7:0]           high_q, high_n;
	logic [7:0]           block_type_q, block_type_n;
	logic [15:0]          remaining_q, remaining_n;
	logic [95:0]          index_q, index_n;
	logic                 finished_q, finished_n;

	logic                 emit;
	kind_t                kind;
	error_code_t          err;
	logic [31:0]          emit_pos;
	logic [16:0]          delta;
	logic                 add_en;
	logic [15:0]          rem_dec;
	logic [15:0]          len;
	logic [TIME_BITS+31:0] time_ext;

	// Next state for one byte or end marker.
	always_comb begin
		state_n      = state_q;
		time_n       = time_q;
		stream_pos_n = stream_pos_q;
		elem_start_n = elem_start_q;
		high_n       = high_q;
		block_type_n = block_type_q;
		remaining_n  = remaining_q;
		index_n      = index_q;
		finished_n   = finished_q;
		emit         = 1'b0;
		kind         = KIND_FLUX;
		err          = ERR_NONE;
		emit_pos     = elem_start_q;
		delta        = '0;
		add_en       = 1'b0;
		rem_dec      = remaining_q - 16'd1;
		len          = {data_byte, high_q};

		if (finished_q) begin
			// The stream has ended; everything else is dropped.
		end else if (end_of_data) begin
			finished_n = 1'b1;
			emit       = 1'b1;
			if (state_q == ST_CODE) begin
				kind     = KIND_END;
				emit_pos = stream_pos_q;
			end else begin
				kind = KIND_ERROR;
				err  = ERR_TRUNCATED;
			end
		end else begin
			stream_pos_n = stream_pos_q + 32'd1;
			unique case (state_q)
				ST_CODE: begin
					elem_start_n = stream_pos_q;
					emit_pos     = stream_pos_q;
					priority if (data_byte < CODE_CELL2_LIMIT) begin
						high_n  = data_byte;
						state_n = ST_CELL_LO;
					end else if (data_byte == CODE_PAD) begin
						state_n = ST_CODE;
					end else if (data_byte == CODE_SKIP1 || data_byte == CODE_SKIP2) begin
						remaining_n = (data_byte == CODE_SKIP1) ? 16'd1 : 16'd2;
						state_n     = ST_SKIP;
					end else if (data_byte == CODE_OVERFLOW) begin
						delta  = OVERFLOW_DELTA;
						add_en = 1'b1;
					end else if (data_byte == CODE_VALUE16) begin
						state_n = ST_V16_HI;
					end else if (data_byte == CODE_OOB) begin
						state_n = ST_OOB_TYPE;
					end else begin
						delta  = {9'b0, data_byte};
						add_en = 1'b1;
						emit   = 1'b1;
					end
				end
				ST_CELL_LO, ST_V16_LO: begin
					delta   = {1'b0, high_q, data_byte};
					add_en  = 1'b1;
					state_n = ST_CODE;
					emit    = 1'b1;
				end
				ST_SKIP: begin
					remaining_n = rem_dec;
					if (rem_dec == 16'd0) begin
						state_n = ST_CODE;
					end
				end
				ST_V16_HI: begin
					high_n  = data_byte;
					state_n = ST_V16_LO;
				end
				ST_OOB_TYPE: begin
					if (data_byte == BLOCK_END) begin
						finished_n = 1'b1;
						state_n    = ST_CODE;
						emit       = 1'b1;
						kind       = KIND_END;
					end else begin
						block_type_n = data_byte;
						state_n      = ST_OOB_LEN_LO;
					end
				end
				ST_OOB_LEN_LO: begin
					high_n  = data_byte;
					state_n = ST_OOB_LEN_HI;
				end
				ST_OOB_LEN_HI: begin
					// Header and data of the block leave the stream position.
					stream_pos_n = stream_pos_q + 32'd1 - {16'b0, len} - OOB_OVERHEAD;
					remaining_n  = len;
					index_n      = '0;
					if (block_type_q == BLOCK_INDEX && len != INDEX_LEN) begin
						if (len == 16'd0) begin
							finished_n = 1'b1;
							state_n    = ST_CODE;
							emit       = 1'b1;
							kind       = KIND_ERROR;
							err        = ERR_BAD_INDEX_LEN;
						end else begin
							state_n = ST_OOB_BAD;
						end
					end else if (len == 16'd0) begin
						state_n = ST_CODE;
					end else begin
						state_n = ST_OOB_DATA;
					end
				end
				ST_OOB_DATA: begin
					// Index bytes arrive little-endian; shift in from the top.
					if (block_type_q == BLOCK_INDEX) begin
						index_n = {data_byte, index_q[95:8]};
					end
					remaining_n = rem_dec;
					if (rem_dec == 16'd0) begin
						state_n = ST_CODE;
						if (block_type_q == BLOCK_INDEX) begin
							emit = 1'b1;
							kind = KIND_INDEX;
						end
					end
				end
				ST_OOB_BAD: begin
					remaining_n = rem_dec;
					if (rem_dec == 16'd0) begin
						finished_n = 1'b1;
						state_n    = ST_CODE;
						emit       = 1'b1;
						kind       = KIND_ERROR;
						err        = ERR_BAD_INDEX_LEN;
					end
				end
				default: begin
					state_n = ST_CODE;
				end
			endcase
		end

		if (add_en) begin
			time_n = time_q + TIME_BITS'(delta);
		end
	end

	// Result fields for the current byte.
	assign time_ext  = {32'b0, time_n};
	assign res_valid = take && emit;

	always_comb begin
		res.kind             = kind;
		res.sample_time      = time_ext[31:0];
		res.element_pos      = emit_pos;
		res.index_stream_pos = (kind == KIND_INDEX) ? index_n[31:0]  : 32'd0;
		res.index_timer      = (kind == KIND_INDEX) ? index_n[63:32] : 32'd0;
		res.index_sys_time   = (kind == KIND_INDEX) ? index_n[95:64] : 32'd0;
		res.error_code       = err;
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CODE;
			time_q       <= '0;
			stream_pos_q <= '0;
			elem_start_q <= '0;
			high_q       <= '0;
			block_type_q <= '0;
			remaining_q  <= '0;
			index_q      <= '0;
			finished_q   <= 1'b0;
		end else if (take) begin
			state_q      <= state_n;
			time_q       <= time_n;
			stream_pos_q <= stream_pos_n;
			elem_start_q <= elem_start_n;
			high_q       <= high_n;
			block_type_q <= block_type_n;
			remaining_q  <= remaining_n;
			index_q      <= index_n;
			finished_q   <= finished_n;
		end
	end

	// Checks on the parser.
	`ASSERT_NEVER(a_no_result_after_finish, clk, arst_n, finished_q && res_valid, "result after stream end")
	`ASSERT_PROP(a_end_sets_finished, clk, arst_n, (res_valid && (res.kind == KIND_END || res.kind == KIND_ERROR)) |=> finished_q, "finish flag not set after end")
	`ASSERT_PROP(a_index_from_data, clk, arst_n, (res_valid && res.kind == KIND_INDEX) |-> (state_q == ST_OOB_DATA && block_type_q == BLOCK_INDEX && remaining_q == 16'd1), "index mark outside index block end")

endmodule

[sv/fsd_out_reg.sv]
// ---------------------------------------------------------------------------
// Flux stream decoder result register
// Holds one result until the consumer takes it.
// ---------------------------------------------------------------------------
module fsd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  fsd_pkg::result_t res_in,
	output logic             space,
	input  logic             result_ready,
	output logic             result_valid,
	output fsd_pkg::result_t res_q
);
	import fsd_pkg::*;

	logic valid_q;

	// Room for a new result when empty or being drained this cycle.
	assign space        = !valid_q || result_ready;
	assign result_valid = valid_q;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

[sv/flux_stream_decoder_top.sv]
// ---------------------------------------------------------------------------
// Flux stream decoder
// Decodes a flux capture stream byte by byte into transitions and marks.
// ---------------------------------------------------------------------------
//  Channel   Handshake                     Payload
//  input     byte_valid / byte_ready       data_byte, end_of_data
//  result    result_valid / result_ready   kind, sample_time, element_pos,
//                                          index_stream_pos, index_timer,
//                                          index_sys_time, error_code
//
// One byte is taken per clock while the result register has room. A byte
// that yields a result passes the input register, then the parser into the
// result register. The parser state loop updates once per byte.
// Reset clears the valid flags and parser state at once; no clearing pass is needed.
// A stalled result holds the parser; the input register still takes one byte.
// ---------------------------------------------------------------------------
module flux_stream_decoder_top #(
	parameter int TIME_BITS = fsd_pkg::TIME_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_data,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  kind,
	output logic [31:0] sample_time,
	output logic [31:0] element_pos,
	output logic [31:0] index_stream_pos,
	output logic [31:0] index_timer,
	output logic [31:0] index_sys_time,
	output logic [1:0]  error_code
);
	import fsd_pkg::*;

	logic       space;
	logic       take;
	logic [7:0] data_s1;
	logic       eod_s1;
	logic       res_valid;
	result_t    res;
	result_t    out_res;

	// Input register.
	fsd_in_stage u_in_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.data_byte   (data_byte),
		.end_of_data (end_of_data),
		.space       (space),
		.take        (take),
		.data_s1     (data_s1),
		.eod_s1      (eod_s1)
	);

	// Stream parser.
	fsd_parser #(
		.TIME_BITS (TIME_BITS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.data_byte   (data_s1),
		.end_of_data (eod_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Result register.
	fsd_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (res_valid),
		.res_in       (res),
		.space        (space),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.res_q        (out_res)
	);

	// Result fields onto their ports.
	assign kind             = out_res.kind;
	assign sample_time      = out_res.sample_time;
	assign element_pos      = out_res.element_pos;
	assign index_stream_pos = out_res.index_stream_pos;
	assign index_timer      = out_res.index_timer;
	assign index_sys_time   = out_res.index_sys_time;
	assign error_code       = out_res.error_code;

endmodule

[tb/flux_stream_decoder_top_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Flux stream decoder testbench
// Feeds byte streams built from whole elements (cells, pads, skips, overflow,
// 16-bit values, index and other out-of-band blocks) with random gaps and
// result stalls. A byte-level decoder in the bench predicts every result and
// a checker compares each result transfer field by field. Reset is applied
// once, so each run closes its stream one way, chosen at random, and then
// checks that later bytes produce nothing.
// ---------------------------------------------------------------------------
module flux_stream_decoder_top_tb;
	import fsd_pkg::*;

	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        end_of_data = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [1:0]  kind;
	logic [31:0] sample_time;
	logic [31:0] element_pos;
	logic [31:0] index_stream_pos;
	logic [31:0] index_timer;
	logic [31:0] index_sys_time;
	logic [1:0]  error_code;

	// Traffic control shared by the test tasks and the receiver.
	bit src_steady = 1'b0;
	bit rx_steady = 1'b0;
	int rx_hold = 0;
	int bytes_sent = 0;
	int mismatches = 0;
	int stall_cycles = 0;

	// Decoder state mirrored by the predictor.
	parse_state_t dec_state = ST_CODE;
	logic [31:0]  acc_time = '0;
	logic [31:0]  bytes_in = '0;
	logic [31:0]  oob_bytes = '0;
	logic [31:0]  elem_pos = '0;
	logic [7:0]   hi_byte = '0;
	logic [7:0]   blk_type = '0;
	logic [15:0]  blk_left = '0;
	logic [31:0]  idx_word [3] = '{default: '0};
	bit           stream_done = 1'b0;
	result_t      pending_results [$];

	flux_stream_decoder_top uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.byte_valid       (byte_valid),
		.byte_ready       (byte_ready),
		.data_byte        (data_byte),
		.end_of_data      (end_of_data),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.kind             (kind),
		.sample_time      (sample_time),
		.element_pos      (element_pos),
		.index_stream_pos (index_stream_pos),
		.index_timer      (index_timer),
		.index_sys_time   (index_sys_time),
		.error_code       (error_code)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Queue one expected result; index words and error code only where the kind uses them.
	function automatic void post_result(kind_t k, logic [31:0] pos, error_code_t ec);
		result_t r;
		r.kind             = k;
		r.sample_time      = acc_time;
		r.element_pos      = pos;
		r.index_stream_pos = (k == KIND_INDEX) ? idx_word[0] : '0;
		r.index_timer      = (k == KIND_INDEX) ? idx_word[1] : '0;
		r.index_sys_time   = (k == KIND_INDEX) ? idx_word[2] : '0;
		r.error_code       = (k == KIND_ERROR) ? ec : ERR_NONE;
		pending_results.insert(pending_results.size(), r);
	endfunction

	// Advance the decoder by one transferred byte.
	function automatic void decode_byte(logic [7:0] b, logic eod);
		logic [15:0] blen;
		logic [3:0]  off;
		if (stream_done)
			return;
		if (eod) begin
			stream_done = 1'b1;
			if (dec_state == ST_CODE)
				post_result(KIND_END, bytes_in - oob_bytes, ERR_NONE);
			else
				post_result(KIND_ERROR, elem_pos, ERR_TRUNCATED);
			return;
		end
		bytes_in++;
		case (dec_state)
			ST_CODE: begin
				elem_pos = bytes_in - 32'd1 - oob_bytes;
				if (b < CODE_CELL2_LIMIT) begin
					hi_byte = b;
					dec_state = ST_CELL_LO;
				end else if (b == CODE_PAD) begin
					// A pad only moves the position on.
				end else if (b == CODE_SKIP1 || b == CODE_SKIP2) begin
					blk_left = 16'(b - CODE_PAD);
					dec_state = ST_SKIP;
				end else if (b == CODE_OVERFLOW) begin
					acc_time += OVERFLOW_DELTA;
				end else if (b == CODE_VALUE16) begin
					dec_state = ST_V16_HI;
				end else if (b == CODE_OOB) begin
					dec_state = ST_OOB_TYPE;
				end else begin
					acc_time += b;
					post_result(KIND_FLUX, elem_pos, ERR_NONE);
				end
			end
			ST_CELL_LO, ST_V16_LO: begin
				acc_time += {hi_byte, b};
				dec_state = ST_CODE;
				post_result(KIND_FLUX, elem_pos, ERR_NONE);
			end
			ST_SKIP: begin
				blk_left--;
				if (blk_left == 0)
					dec_state = ST_CODE;
			end
			ST_V16_HI: begin
				hi_byte = b;
				dec_state = ST_V16_LO;
			end
			ST_OOB_TYPE: begin
				if (b == BLOCK_END) begin
					stream_done = 1'b1;
					dec_state = ST_CODE;
					post_result(KIND_END, elem_pos, ERR_NONE);
				end else begin
					blk_type = b;
					dec_state = ST_OOB_LEN_LO;
				end
			end
			ST_OOB_LEN_LO: begin
				hi_byte = b;
				dec_state = ST_OOB_LEN_HI;
			end
			ST_OOB_LEN_HI: begin
				blen = {b, hi_byte};
				oob_bytes += blen + OOB_OVERHEAD;
				blk_left = blen;
				idx_word = '{default: '0};
				if (blk_type == BLOCK_INDEX && blen != INDEX_LEN) begin
					if (blen == 0) begin
						stream_done = 1'b1;
						dec_state = ST_CODE;
						post_result(KIND_ERROR, elem_pos, ERR_BAD_INDEX_LEN);
					end else begin
						dec_state = ST_OOB_BAD;
					end
				end else if (blen == 0) begin
					dec_state = ST_CODE;
				end else begin
					dec_state = ST_OOB_DATA;
				end
			end
			ST_OOB_DATA: begin
				// Index data assembles three little-endian words.
				if (blk_type == BLOCK_INDEX) begin
					off = 4'(INDEX_LEN - blk_left);
					if (off < 4'd12)
						idx_word[off[3:2]] |= 32'(b) << (8 * off[1:0]);
				end
				blk_left--;
				if (blk_left == 0) begin
					dec_state = ST_CODE;
					if (blk_type == BLOCK_INDEX)
						post_result(KIND_INDEX, elem_pos, ERR_NONE);
				end
			end
			ST_OOB_BAD: begin
				blk_left--;
				if (blk_left == 0) begin
					stream_done = 1'b1;
					dec_state = ST_CODE;
					post_result(KIND_ERROR, elem_pos, ERR_BAD_INDEX_LEN);
				end
			end
			default: dec_state = ST_CODE;
		endcase
	endfunction

	// Offer one byte, hold it until the transfer, then predict its result.
	task automatic send_item(logic [7:0] b, logic eod);
		while (!src_steady && $urandom_range(99) < 28) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid  <= 1'b1;
		data_byte   <= b;
		end_of_data <= eod;
		do
			@(posedge clk);
		while (!byte_ready);
		bytes_sent++;
		decode_byte(b, eod);
	endtask

	task automatic send_byte(logic [7:0] b);
		send_item(b, 1'b0);
	endtask

	// Out-of-band block header followed by random payload bytes.
	task automatic send_oob_block(logic [7:0] btype, logic [15:0] blen);
		send_byte(CODE_OOB);
		send_byte(btype);
		send_byte(blen[7:0]);
		send_byte(blen[15:8]);
		repeat (blen)
			send_byte(8'($urandom));
	endtask

	// One complete element of a random kind with random content.
	task automatic send_element();
		int          pick;
		logic [7:0]  btype;
		logic [15:0] blen;
		pick = $urandom_range(99);
		if (pick < 38) begin
			send_byte(8'($urandom_range(255, 14)));
		end else if (pick < 56) begin
			send_byte(8'($urandom_range(7)));
			send_byte(8'($urandom));
		end else if (pick < 60) begin
			send_byte(CODE_PAD);
		end else if (pick < 66) begin
			send_byte(pick[0] ? CODE_SKIP1 : CODE_SKIP2);
			repeat (pick[0] ? 1 : 2)
				send_byte(8'($urandom));
		end else if (pick < 71) begin
			send_byte(CODE_OVERFLOW);
		end else if (pick < 82) begin
			send_byte(CODE_VALUE16);
			send_byte(8'($urandom));
			send_byte(8'($urandom));
		end else if (pick < 90) begin
			send_oob_block(BLOCK_INDEX, INDEX_LEN);
		end else begin
			do
				btype = 8'($urandom);
			while (btype == BLOCK_INDEX || btype == BLOCK_END);
			blen = ($urandom_range(19) == 0) ? 16'($urandom_range(300, 17))
			                                 : 16'($urandom_range(16));
			send_oob_block(btype, blen);
		end
	endtask

	// Extremes of each byte code, an empty out-of-band block and an index block.
	task automatic test_directed_codes();
		send_byte(8'd14);
		send_byte(8'd255);
		send_byte(CODE_PAD);
		send_byte(8'd7);
		send_byte(8'hFF);
		send_byte(8'd0);
		send_byte(8'd0);
		send_byte(CODE_SKIP1);
		send_byte(CODE_OOB);
		send_byte(CODE_SKIP2);
		send_byte(CODE_OOB);
		send_byte(CODE_OOB);
		send_byte(CODE_OVERFLOW);
		send_byte(CODE_VALUE16);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_oob_block(8'h55, 16'd0);
		send_oob_block(BLOCK_INDEX, INDEX_LEN);
	endtask

	// Random well-formed elements until about n_items bytes have gone out.
	task automatic test_random_stream(int n_items, bit steady);
		int start;
		start = bytes_sent;
		src_steady = steady;
		rx_steady = steady;
		while (bytes_sent - start < n_items)
			send_element();
		src_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// Receiver holds off while cells keep coming, so the input must stall.
	task automatic test_result_backpressure();
		rx_hold = HOLD_CYCLES;
		src_steady = 1'b1;
		repeat (60)
			send_byte(8'($urandom_range(255, 14)));
		src_steady = 1'b0;
	endtask

	// Close the stream one way, picked at random since only one close fits a reset.
	task automatic test_stream_close();
		logic [7:0]  prefix [$];
		logic [7:0]  btype;
		logic [15:0] blen;
		int          k;
		case ($urandom_range(4))
			0: begin
				// Data ends between elements.
				send_item(8'($urandom), 1'b1);
			end
			1: begin
				// End block.
				send_byte(CODE_OOB);
				send_byte(BLOCK_END);
			end
			2: begin
				// Data ends inside an element.
				case ($urandom_range(7))
					0: prefix = '{8'($urandom_range(7))};
					1: prefix = '{CODE_VALUE16};
					2: prefix = '{CODE_VALUE16, 8'($urandom)};
					3: prefix = '{CODE_SKIP1};
					4: prefix = '{CODE_SKIP2, 8'($urandom)};
					5: prefix = '{CODE_OOB};
					6: prefix = '{CODE_OOB, BLOCK_INDEX, 8'($urandom)};
					default: begin
						if ($urandom_range(1)) begin
							btype = BLOCK_INDEX;
							blen = INDEX_LEN;
						end else begin
							btype = 8'($urandom_range(12, 3));
							blen = 16'($urandom_range(20, 1));
						end
						prefix = '{CODE_OOB, btype, blen[7:0], blen[15:8]};
						repeat ($urandom_range(blen - 1))
							prefix.insert(prefix.size(), 8'($urandom));
					end
				endcase
				foreach (prefix[i])
					send_byte(prefix[i]);
				send_item(8'($urandom), 1'b1);
			end
			3: begin
				// Index block of the wrong length, empty ones included.
				do
					blen = 16'($urandom_range(40));
				while (blen == INDEX_LEN);
				send_oob_block(BLOCK_INDEX, blen);
			end
			default: begin
				// Wrong-length index block cut short by the end of data.
				do
					blen = 16'($urandom_range(40, 2));
				while (blen == INDEX_LEN);
				k = $urandom_range(blen - 1);
				send_byte(CODE_OOB);
				send_byte(BLOCK_INDEX);
				send_byte(blen[7:0]);
				send_byte(blen[15:8]);
				repeat (k)
					send_byte(8'($urandom));
				send_item(8'($urandom), 1'b1);
			end
		endcase
	endtask

	// Once closed, further bytes and end marks must give nothing.
	task automatic test_after_close();
		repeat (24)
			send_item(8'($urandom), 1'($urandom_range(1)));
	endtask

	// Result receiver: random stalls, steady stretches, and one long hold-off.
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				result_ready <= 1'b0;
				repeat (rx_hold)
					@(posedge clk);
				rx_hold = 0;
			end
			result_ready <= rx_steady || $urandom_range(99) >= 28;
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Compare each result transfer with the oldest prediction.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: kind %0d element_pos 0x%0h",
					kind, element_pos);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(kind));
				check_field("sample_time", want.sample_time, sample_time);
				check_field("element_pos", want.element_pos, element_pos);
				check_field("index_stream_pos", want.index_stream_pos, index_stream_pos);
				check_field("index_timer", want.index_timer, index_timer);
				check_field("index_sys_time", want.index_sys_time, index_sys_time);
				check_field("error_code", 32'(want.error_code), 32'(error_code));
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && byte_ready) || (result_valid && result_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("flux_stream_decoder_top_tb: errors");
				$finish;
			end
		end
	end

	initial begin : main
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_codes();
		test_random_stream(450, 1'b0);
		test_random_stream(200, 1'b1);
		test_result_backpressure();
		test_random_stream(450, 1'b0);
		test_stream_close();
		test_after_close();
		byte_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("flux_stream_decoder_top_tb: clean");
		else
			$display("flux_stream_decoder_top_tb: errors");
		$finish;
	end

endmodule
